// ----- src/rcfm_pkg.sv -----
// Package for the relay current fault monitor.
// Holds opcode and fault-kind codes, register indexes and the shared structs.
// No dependencies.
package rcfm_pkg;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_SEED  = 2'd1,
      OP_EVAL  = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_OVER = 2'd1,
      KIND_ZERO = 2'd2
   } fault_kind_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_MON_EN = 2'd0;
   localparam logic [1:0] CSR_SETTLE = 2'd1;
   localparam logic [1:0] CSR_STREAK = 2'd2;

   localparam logic        MON_EN_RESET = 1'b1;
   localparam logic [15:0] SETTLE_RESET = 16'd100;
   localparam logic [3:0]  STREAK_RESET = 4'd6;

   typedef struct packed {
      logic        mon_en;
      logic [15:0] settle;
      logic [3:0]  streak_limit;
   } cfg_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [31:0] now_ms;
      logic        channel_enabled;
      logic        drive_on;
      logic [15:0] on_time_ms;
      logic [15:0] limit_ma;
      logic [15:0] sense_ma;
   } item_type;

   typedef struct packed {
      logic [3:0]  over_streak;
      logic [3:0]  zero_streak;
      logic        pending;
      logic [31:0] deadline;
      logic        last_relay;
      logic [15:0] display_ma;
      logic [15:0] previous_ma;
   } chan_type;

   typedef struct packed {
      logic           raised;
      fault_kind_type kind;
      logic           taken;
      logic [15:0]    shown_ma;
      logic [3:0]     over_count;
      logic [3:0]     zero_count;
   } result_type;

endpackage

// ----- src/rcfm_eval.sv -----
// Per-item update of one channel's state for the relay current fault monitor.
// Pure combinational; depends on rcfm_pkg.
module rcfm_eval
   import rcfm_pkg::*;
(
   input  item_type   item,
   input  logic       chan_ok,
   input  logic       latched,
   input  cfg_type    cfg,
   input  chan_type   chan_cur,
   output chan_type   chan_nxt,
   output logic       latch_set,
   output result_type result
);

   logic [3:0]  slim;
   logic [15:0] settle;
   logic [31:0] deadline_new;
   logic        relay_flip;
   logic        over_cond;
   logic        zero_cond;

   always_comb begin
      slim = (cfg.streak_limit == 4'd0) ? 4'd1 : cfg.streak_limit;
      // Rising edge takes a nonzero on-time when it is shorter than the settle time
      settle = (item.drive_on && item.on_time_ms != 16'd0 && item.on_time_ms < cfg.settle)
               ? item.on_time_ms : cfg.settle;
      deadline_new = item.now_ms + {16'd0, settle};
      relay_flip = item.drive_on != chan_cur.last_relay;
      over_cond = (item.limit_ma != 16'd0) &&
                  ((item.sense_ma > item.limit_ma) || (chan_cur.previous_ma > item.limit_ma));
      zero_cond = (item.sense_ma == 16'd0) && (chan_cur.previous_ma == 16'd0);
   end

   always_comb begin
      chan_nxt      = chan_cur;
      latch_set     = 1'b0;
      result.raised = 1'b0;
      result.kind   = KIND_NONE;
      result.taken  = 1'b0;
      case (item.opcode)
         OP_START: begin
            chan_nxt.over_streak = 4'd0;
            chan_nxt.zero_streak = 4'd0;
            chan_nxt.pending     = 1'b0;
            chan_nxt.deadline    = 32'd0;
            chan_nxt.last_relay  = 1'b0;
            chan_nxt.display_ma  = 16'd0;
         end
         OP_SEED: begin
            chan_nxt.previous_ma = item.sense_ma;
         end
         OP_EVAL: begin
            if (!latched) begin
               if (!item.channel_enabled) begin
                  chan_nxt.over_streak = 4'd0;
                  chan_nxt.zero_streak = 4'd0;
                  chan_nxt.pending     = 1'b0;
                  chan_nxt.last_relay  = 1'b0;
                  chan_nxt.display_ma  = 16'd0;
               end else begin
                  if (relay_flip) begin
                     chan_nxt.pending    = 1'b1;
                     chan_nxt.deadline   = deadline_new;
                     chan_nxt.last_relay = item.drive_on;
                  end
                  if (chan_nxt.pending && item.now_ms >= chan_nxt.deadline) begin
                     chan_nxt.pending    = 1'b0;
                     chan_nxt.display_ma = item.sense_ma;
                     result.taken        = 1'b1;
                     if (cfg.mon_en) begin
                        if (over_cond) begin
                           if (chan_cur.over_streak < slim) begin
                              chan_nxt.over_streak = chan_cur.over_streak + 4'd1;
                           end
                        end else begin
                           chan_nxt.over_streak = 4'd0;
                        end
                        if (zero_cond) begin
                           if (chan_cur.zero_streak < slim) begin
                              chan_nxt.zero_streak = chan_cur.zero_streak + 4'd1;
                           end
                        end else begin
                           chan_nxt.zero_streak = 4'd0;
                        end
                        chan_nxt.previous_ma = item.sense_ma;
                        if (chan_nxt.zero_streak >= slim || chan_nxt.over_streak >= slim) begin
                           latch_set     = 1'b1;
                           result.raised = 1'b1;
                           result.kind   = (chan_nxt.zero_streak >= slim) ? KIND_ZERO
                                                                          : KIND_OVER;
                        end
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase
      // Out-of-range channels report zeros and must not raise anything
      if (!chan_ok) begin
         latch_set     = 1'b0;
         result.raised = 1'b0;
         result.kind   = KIND_NONE;
         result.taken  = 1'b0;
      end
      result.shown_ma   = chan_ok ? chan_nxt.display_ma  : 16'd0;
      result.over_count = chan_ok ? chan_nxt.over_streak : 4'd0;
      result.zero_count = chan_ok ? chan_nxt.zero_streak : 4'd0;
   end

endmodule

// ----- src/relay_current_fault_monitor.sv -----
// Top level of the relay current fault monitor: handshake, channel state and
// configuration registers. Depends on rcfm_pkg and rcfm_eval.
//
// Path: an accepted item passes the input register, then the result register;
//   the channel update happens as the item moves on.
// Throughput: one item per cycle while results are taken; a stalled result
//   holds the input once the input register is full.
// Reset (synchronous, active high): clears all channel state, the fault latch
//   and both pipeline valids, and loads the register defaults.
module relay_current_fault_monitor
   import rcfm_pkg::*;
#(
   parameter int CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   // configuration writes
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   // item input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_channel,
   input  logic [31:0] req_now_ms,
   input  logic        req_channel_enabled,
   input  logic        req_drive_on,
   input  logic [15:0] req_on_time_ms,
   input  logic [15:0] req_limit_ma,
   input  logic [15:0] req_sense_ma,
   // result output
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_fault_raised,
   output logic [1:0]  rsp_fault_kind,
   output logic        rsp_sample_taken,
   output logic [15:0] rsp_shown_ma,
   output logic [3:0]  rsp_over_count,
   output logic [3:0]  rsp_zero_count
);

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   // Configuration registers
   cfg_type cfg_ff;

   // Input register stage
   logic        stg_valid_ff;
   logic [1:0]  stg_channel_ff;
   item_type    stg_item_ff;

   // Channel state and global fault latch
   chan_type    chan_ff [CHANNELS];
   logic        latched_ff;

   // Result register
   logic        rsp_valid_ff;
   result_type  rsp_ff;

   logic        advance;
   logic        chan_ok;
   logic [IDX_W-1:0] chan_idx;
   chan_type    chan_cur;
   chan_type    chan_nxt;
   logic        latch_set;
   result_type  result_in;
   item_type    item_in;

   // Move the staged item into the result register when that slot frees up
   assign advance   = stg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || advance;

   assign chan_ok  = 5'(stg_channel_ff) < 5'(CHANNELS);
   assign chan_idx = IDX_W'(stg_channel_ff);
   assign chan_cur = chan_ok ? chan_ff[chan_idx] : '0;

   always_comb begin
      item_in.opcode          = opcode_type'(req_opcode);
      item_in.now_ms          = req_now_ms;
      item_in.channel_enabled = req_channel_enabled;
      item_in.drive_on        = req_drive_on;
      item_in.on_time_ms      = req_on_time_ms;
      item_in.limit_ma        = req_limit_ma;
      item_in.sense_ma        = req_sense_ma;
   end

   rcfm_eval u_eval (
      .item      (stg_item_ff),
      .chan_ok   (chan_ok),
      .latched   (latched_ff),
      .cfg       (cfg_ff),
      .chan_cur  (chan_cur),
      .chan_nxt  (chan_nxt),
      .latch_set (latch_set),
      .result    (result_in)
   );

   // Configuration writes; unknown indexes drop
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mon_en       <= MON_EN_RESET;
         cfg_ff.settle       <= SETTLE_RESET;
         cfg_ff.streak_limit <= STREAK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_MON_EN: cfg_ff.mon_en       <= csr_wdata[0];
            CSR_SETTLE: cfg_ff.settle       <= csr_wdata;
            CSR_STREAK: cfg_ff.streak_limit <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // Input stage: hold the item until it advances
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else if (req_ready) begin
         stg_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_channel_ff <= req_channel;
         stg_item_ff    <= item_in;
      end
   end

   // Channel state: a start item clears every channel but keeps the seeded
   // previous current; other items write back only their own channel
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
         latched_ff <= 1'b0;
      end else if (advance) begin
         if (stg_item_ff.opcode == OP_START) begin
            for (int i = 0; i < CHANNELS; i++) begin
               chan_ff[i].over_streak <= 4'd0;
               chan_ff[i].zero_streak <= 4'd0;
               chan_ff[i].pending     <= 1'b0;
               chan_ff[i].deadline    <= 32'd0;
               chan_ff[i].last_relay  <= 1'b0;
               chan_ff[i].display_ma  <= 16'd0;
            end
            latched_ff <= 1'b0;
         end else begin
            if (chan_ok) begin
               chan_ff[chan_idx] <= chan_nxt;
            end
            if (latch_set) begin
               latched_ff <= 1'b1;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fault_raised = rsp_ff.raised;
   assign rsp_fault_kind   = rsp_ff.kind;
   assign rsp_sample_taken = rsp_ff.taken;
   assign rsp_shown_ma     = rsp_ff.shown_ma;
   assign rsp_over_count   = rsp_ff.over_count;
   assign rsp_zero_count   = rsp_ff.zero_count;

endmodule

// ----- src/rcfm_checker.sv -----
// Port-level checks for the relay current fault monitor, bound to the top.
// Depends on rcfm_pkg and relay_current_fault_monitor.
module rcfm_checker
   import rcfm_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_fault_raised,
   input logic [1:0]  rsp_fault_kind,
   input logic        rsp_sample_taken,
   input logic [15:0] rsp_shown_ma,
   input logic [3:0]  rsp_over_count,
   input logic [3:0]  rsp_zero_count
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_fault_raised) &&
      $stable(rsp_fault_kind) && $stable(rsp_shown_ma) && $stable(rsp_over_count) &&
      $stable(rsp_zero_count) && $stable(rsp_sample_taken))
      else $error("result changed while stalled");

   // No result right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Kind is none exactly when no fault is raised
   a_kind_none: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fault_raised |-> rsp_fault_kind == KIND_NONE)
      else $error("fault kind without fault");

   a_kind_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_raised |->
      (rsp_fault_kind == KIND_OVER || rsp_fault_kind == KIND_ZERO) && rsp_sample_taken)
      else $error("fault raised without kind or sample");

   // A zero-current fault needs a nonzero zero streak
   a_zero_streak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_raised && rsp_fault_kind == KIND_ZERO |->
      rsp_zero_count != 4'd0)
      else $error("zero fault with empty streak");

endmodule

bind relay_current_fault_monitor rcfm_checker u_rcfm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_fault_raised (rsp_fault_raised),
   .rsp_fault_kind   (rsp_fault_kind),
   .rsp_sample_taken (rsp_sample_taken),
   .rsp_shown_ma     (rsp_shown_ma),
   .rsp_over_count   (rsp_over_count),
   .rsp_zero_count   (rsp_zero_count)
);

// ----- tb/relay_current_fault_monitor_checker.sv -----
// Result checker for the relay current fault monitor: keeps its own copy of the
// channel state and registers, predicts one result per item and compares.
// Depends on rcfm_pkg; instantiated beside the block by the testbench top.
module relay_current_fault_monitor_checker
   import rcfm_pkg::*;
#(
   parameter int CHANNELS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [1:0]  req_opcode,
   input  logic [1:0]  req_channel,
   input  logic [31:0] req_now_ms,
   input  logic        req_channel_enabled,
   input  logic        req_drive_on,
   input  logic [15:0] req_on_time_ms,
   input  logic [15:0] req_limit_ma,
   input  logic [15:0] req_sense_ma,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_fault_raised,
   input  logic [1:0]  rsp_fault_kind,
   input  logic        rsp_sample_taken,
   input  logic [15:0] rsp_shown_ma,
   input  logic [3:0]  rsp_over_count,
   input  logic [3:0]  rsp_zero_count,
   output int          mismatch_count,
   output int          results_due,
   output int          samples_seen,
   output int          faults_seen
);

   cfg_type    cfg;
   chan_type   chans [CHANNELS];
   logic       fault_latched;
   result_type expected_q [$];
   int         results_checked;

   // Advance the mirrored state by one item and return the result it causes.
   function automatic result_type monitor_step(
      input logic [1:0]  op,
      input logic [1:0]  ch,
      input logic [31:0] now_ms,
      input logic        en,
      input logic        drive_on,
      input logic [15:0] on_time_ms,
      input logic [15:0] limit_ma,
      input logic [15:0] sense_ma
   );
      result_type  res;
      chan_type    c;
      logic [3:0]  slim;
      logic [31:0] settle;
      logic [15:0] prev_ma;
      logic [15:0] keep_ma;
      logic        in_range;
      res = '0;
      res.kind = KIND_NONE;
      slim = (cfg.streak_limit == 4'd0) ? 4'd1 : cfg.streak_limit;
      in_range = (int'(ch) < CHANNELS);
      if (op == OP_START) begin
         // previous current survives a start, everything else is cleared
         for (int i = 0; i < CHANNELS; i++) begin
            keep_ma = chans[i].previous_ma;
            chans[i] = '0;
            chans[i].previous_ma = keep_ma;
         end
         fault_latched = 1'b0;
      end else if (op == OP_SEED && in_range) begin
         chans[ch].previous_ma = sense_ma;
      end else if (op == OP_EVAL && in_range && !fault_latched) begin
         c = chans[ch];
         if (!en) begin
            c.over_streak = '0;
            c.zero_streak = '0;
            c.pending = 1'b0;
            c.last_relay = 1'b0;
            c.display_ma = '0;
         end else begin
            if (drive_on != c.last_relay) begin
               settle = {16'd0, cfg.settle};
               if (drive_on && on_time_ms != 16'd0 && on_time_ms < cfg.settle)
                  settle = {16'd0, on_time_ms};
               c.pending = 1'b1;
               c.deadline = now_ms + settle;
               c.last_relay = drive_on;
            end
            // plain unsigned compare, no wrap handling
            if (c.pending && now_ms >= c.deadline) begin
               prev_ma = c.previous_ma;
               c.pending = 1'b0;
               res.taken = 1'b1;
               c.display_ma = sense_ma;
               if (cfg.mon_en) begin
                  if (limit_ma != 16'd0 && (sense_ma > limit_ma || prev_ma > limit_ma)) begin
                     if (c.over_streak < slim) c.over_streak = c.over_streak + 4'd1;
                  end else begin
                     c.over_streak = '0;
                  end
                  if (sense_ma == 16'd0 && prev_ma == 16'd0) begin
                     if (c.zero_streak < slim) c.zero_streak = c.zero_streak + 4'd1;
                  end else begin
                     c.zero_streak = '0;
                  end
                  c.previous_ma = sense_ma;
                  if (c.zero_streak >= slim || c.over_streak >= slim) begin
                     fault_latched = 1'b1;
                     res.raised = 1'b1;
                     res.kind = (c.zero_streak >= slim) ? KIND_ZERO : KIND_OVER;
                  end
               end
            end
         end
         chans[ch] = c;
      end
      if (in_range) begin
         res.shown_ma = chans[ch].display_ma;
         res.over_count = chans[ch].over_streak;
         res.zero_count = chans[ch].zero_streak;
      end
      return res;
   endfunction

   function automatic void check_field(input string field, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("checker: result %0d field %s expected %0h actual %0h",
                     results_checked, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      result_type exp_res;
      if (reset) begin
         cfg.mon_en = MON_EN_RESET;
         cfg.settle = SETTLE_RESET;
         cfg.streak_limit = STREAK_RESET;
         for (int i = 0; i < CHANNELS; i++) chans[i] = '0;
         fault_latched = 1'b0;
         expected_q.delete();
         results_checked = 0;
      end else begin
         // retire the output first: it belongs to an older item
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("checker: result with no item outstanding");
            end else begin
               exp_res = expected_q.pop_front();
               check_field("fault_raised", 16'(exp_res.raised), 16'(rsp_fault_raised));
               check_field("fault_kind", 16'(exp_res.kind), 16'(rsp_fault_kind));
               check_field("sample_taken", 16'(exp_res.taken), 16'(rsp_sample_taken));
               check_field("shown_ma", exp_res.shown_ma, rsp_shown_ma);
               check_field("over_count", 16'(exp_res.over_count), 16'(rsp_over_count));
               check_field("zero_count", 16'(exp_res.zero_count), 16'(rsp_zero_count));
               results_checked++;
            end
         end
         if (req_valid && req_ready) begin
            exp_res = monitor_step(req_opcode, req_channel, req_now_ms, req_channel_enabled,
                                   req_drive_on, req_on_time_ms, req_limit_ma,
                                   req_sense_ma);
            if (exp_res.taken) samples_seen++;
            if (exp_res.raised) faults_seen++;
            expected_q.push_back(exp_res);
         end
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MON_EN: cfg.mon_en = csr_wdata[0];
               CSR_SETTLE: cfg.settle = csr_wdata;
               CSR_STREAK: cfg.streak_limit = csr_wdata[3:0];
               default: ;
            endcase
         end
      end
      results_due <= expected_q.size();
   end

endmodule

// ----- tb/relay_current_fault_monitor_tb.sv -----
// Testbench top for the relay current fault monitor: clock, reset, stimulus,
// register settings and the verdict. Depends on rcfm_pkg, the block and
// relay_current_fault_monitor_checker.
module relay_current_fault_monitor_tb;
   import rcfm_pkg::*;

   // Opcode that the block ignores; the package names only the used ones.
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;
   localparam int PHASES = 10;
   localparam int PHASE_ITEMS = 162;

   // Load profile of a channel within one test run.
   typedef enum int {LOAD_NORMAL, LOAD_OVER, LOAD_ZERO, LOAD_ANY} load_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_opcode;
   logic [1:0]  req_channel;
   logic [31:0] req_now_ms;
   logic        req_channel_enabled;
   logic        req_drive_on;
   logic [15:0] req_on_time_ms;
   logic [15:0] req_limit_ma;
   logic [15:0] req_sense_ma;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_fault_raised;
   logic [1:0]  rsp_fault_kind;
   logic        rsp_sample_taken;
   logic [15:0] rsp_shown_ma;
   logic [3:0]  rsp_over_count;
   logic [3:0]  rsp_zero_count;

   int mismatch_count;
   int results_due;
   int samples_seen;
   int faults_seen;

   int          cycle_count;
   int          items_sent;
   int          evals_sent;
   int          starts_sent;
   int          settings_used;
   logic        req_hurry;
   logic        rsp_hurry;
   logic [31:0] wall_ms;
   logic        relay_drv [4];
   load_type    load [4];
   cfg_type     cur_cfg;

   relay_current_fault_monitor dut (.*);

   relay_current_fault_monitor_checker u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop in case the block hangs or drops a result.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("relay_current_fault_monitor_tb: errors");
         $finish;
      end
   end

   // Result side: draw a stall per result, with stretches of no stalls at all.
   initial begin : drain
      int stall;
      rsp_ready <= 1'b0;
      rsp_hurry = 1'b0;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_hurry = !rsp_hurry;
         stall = rsp_hurry ? 0 : $urandom_range(0, 19);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Present one item after a random gap and hold it until accepted.
   task automatic send_item(input logic [1:0] op, input logic [1:0] ch,
                            input logic [31:0] now_ms, input logic en, input logic ron,
                            input logic [15:0] ton, input logic [15:0] lim,
                            input logic [15:0] cur);
      int gap;
      gap = req_hurry ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_opcode <= op;
      req_channel <= ch;
      req_now_ms <= now_ms;
      req_channel_enabled <= en;
      req_drive_on <= ron;
      req_on_time_ms <= ton;
      req_limit_ma <= lim;
      req_sense_ma <= cur;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
      if (op == OP_EVAL) evals_sent++;
      if (op == OP_START) starts_sent++;
   endtask

   // Drop valid and hold until every outstanding result has come back.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Write all three registers back to back, only with the block idle.
   task automatic write_config(input logic mon, input logic [15:0] settle,
                               input logic [3:0] streak);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MON_EN;
      csr_wdata <= {15'd0, mon};
      @(posedge clock);
      csr_index <= CSR_SETTLE;
      csr_wdata <= settle;
      @(posedge clock);
      csr_index <= CSR_STREAK;
      csr_wdata <= {12'd0, streak};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_cfg.mon_en = mon;
      cur_cfg.settle = settle;
      cur_cfg.streak_limit = streak;
      settings_used++;
   endtask

   function automatic void pick_load(input load_type kind, output logic [15:0] lim,
                                     output logic [15:0] cur);
      case (kind)
         LOAD_NORMAL: begin
            lim = 16'($urandom_range(100, 65535));
            cur = 16'($urandom_range(1, lim));
         end
         LOAD_OVER: begin
            lim = 16'($urandom_range(1, 65534));
            cur = 16'($urandom_range(lim + 1, 65535));
         end
         LOAD_ZERO: begin
            lim = 16'($urandom_range(0, 65535));
            cur = '0;
         end
         default: begin
            lim = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
            cur = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
         end
      endcase
   endfunction

   // One evaluate item: advance time, maybe flip the relay, load per profile.
   task automatic send_eval(input logic [1:0] ch);
      int unsigned span;
      int unsigned step;
      logic        en;
      logic [15:0] ton;
      logic [15:0] lim;
      logic [15:0] cur;
      span = int'(cur_cfg.settle);
      case ($urandom_range(0, 19))
         0: step = 0;
         1: step = $urandom();   // long jump, wraps the clock now and then
         default: step = $urandom_range(0, span + span / 2 + 4);
      endcase
      wall_ms = wall_ms + step;
      en = ($urandom_range(0, 24) != 0);
      if (!en) relay_drv[ch] = 1'b0;
      else if ($urandom_range(0, 1) == 1) relay_drv[ch] = !relay_drv[ch];
      // on-time mostly near the settle time so it shortens it often
      if ($urandom_range(0, 3) == 0) ton = 16'($urandom_range(0, 65535));
      else ton = (span + 2 > 65535) ? 16'hFFFF : 16'($urandom_range(0, span + 2));
      pick_load(($urandom_range(0, 9) == 0) ? LOAD_ANY : load[ch], lim, cur);
      send_item(OP_EVAL, ch, wall_ms, en, en ? relay_drv[ch] : 1'($urandom_range(0, 1)),
                ton, lim, cur);
   endtask

   // A test run: usually a start, some seeds, then evaluates that favor
   // one channel so that streaks can build up to a fault.
   task automatic run_sequence();
      int          evals;
      logic [1:0]  focus;
      logic [1:0]  ch;
      logic [15:0] lim;
      logic [15:0] cur;
      req_hurry = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) != 0)
         send_item(OP_START, 2'($urandom_range(0, 3)), $urandom(), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      for (int c = 0; c < 4; c++) begin
         load[c] = load_type'($urandom_range(0, 3));
         relay_drv[c] = 1'b0;
         if ($urandom_range(0, 1) == 1) begin
            pick_load(load[c], lim, cur);
            send_item(OP_SEED, 2'(c), $urandom(), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)), lim, cur);
         end
      end
      focus = 2'($urandom_range(0, 3));
      evals = $urandom_range(8, 90);
      repeat (evals) begin
         ch = ($urandom_range(0, 9) < 6) ? focus : 2'($urandom_range(0, 3));
         case ($urandom_range(0, 39))
            0: send_item(OP_UNUSED, ch, $urandom(), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                         16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
            1: begin
               pick_load(LOAD_ANY, lim, cur);
               send_item(OP_SEED, ch, wall_ms, 1'b1, 1'b0, 16'd0, lim, cur);
            end
            default: send_eval(ch);
         endcase
      end
   endtask

   initial begin : stimulus
      int phase_base;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_MON_EN;
      csr_wdata <= '0;
      req_valid <= 1'b0;
      req_opcode <= OP_START;
      req_channel <= '0;
      req_now_ms <= '0;
      req_channel_enabled <= 1'b0;
      req_drive_on <= 1'b0;
      req_on_time_ms <= '0;
      req_limit_ma <= '0;
      req_sense_ma <= '0;
      req_hurry = 1'b0;
      wall_ms = '0;
      cur_cfg.mon_en = MON_EN_RESET;
      cur_cfg.settle = SETTLE_RESET;
      cur_cfg.streak_limit = STREAK_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part, register defaults: settle 100, streak 6, monitoring on.
      send_item(OP_START, 2'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_SEED, 2'd0, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'hFFFF);
      // on-time above the settle time leaves the deadline at now + 100
      send_item(OP_EVAL, 2'd0, 32'd0, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_EVAL, 2'd0, 32'd99, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // sample exactly at the deadline; current equal to the limit is not over
      send_item(OP_EVAL, 2'd0, 32'd100, 1'b1, 1'b1, 16'd0, 16'hFFFF, 16'hFFFF);
      // short on-time shortens the settle; a zero limit disables overcurrent
      send_item(OP_EVAL, 2'd1, 32'd200, 1'b1, 1'b1, 16'd1, 16'd0, 16'hFFFF);
      send_item(OP_EVAL, 2'd1, 32'd201, 1'b1, 1'b1, 16'd0, 16'd0, 16'hFFFF);
      // falling edge ignores the on-time
      send_item(OP_EVAL, 2'd1, 32'd300, 1'b1, 1'b0, 16'd5, 16'd1, 16'd2);
      send_item(OP_EVAL, 2'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, 16'd0, 16'd1, 16'd2);
      // disabled channel clears its state
      send_item(OP_EVAL, 2'd2, 32'd500, 1'b0, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_item(OP_UNUSED, 2'd3, 32'hFFFF_FFFF, 1'b1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      // deadline wraps past zero, so the sample is taken at once
      send_item(OP_EVAL, 2'd3, 32'hFFFF_FFF0, 1'b1, 1'b1, 16'd0, 16'd100, 16'd0);
      send_item(OP_SEED, 2'd3, 32'd0, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);

      // Monitoring off with zero settle: samples only update the display.
      write_config(1'b0, 16'd0, 4'd6);
      send_item(OP_EVAL, 2'd0, 32'd1000, 1'b1, 1'b0, 16'd0, 16'd10, 16'd0);

      // A streak limit of zero acts as one: first bad sample faults.
      write_config(1'b1, 16'd0, 4'd0);
      send_item(OP_EVAL, 2'd0, 32'd1001, 1'b1, 1'b1, 16'd5, 16'd10, 16'd0);
      // frozen: evaluates change nothing, seeds still act
      send_item(OP_EVAL, 2'd3, 32'd1002, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0);
      send_item(OP_SEED, 2'd2, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
      send_item(OP_START, 2'd1, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);
      send_item(OP_EVAL, 2'd2, 32'd1003, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0);
      send_item(OP_START, 2'd2, 32'd0, 1'b0, 1'b0, 16'd0, 16'd0, 16'd0);

      // Random part: one register setting per phase, extremes first.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: write_config(1'b1, 16'd0, 4'd1);
            1: write_config(1'b1, 16'hFFFF, 4'd15);
            2: write_config(1'b0, 16'd100, 4'd6);
            3: write_config(1'b1, 16'd1, 4'd0);
            default: write_config($urandom_range(0, 5) != 0,
                                  ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                              : 16'($urandom_range(0, 300)),
                                  4'($urandom_range(0, 15)));
         endcase
         phase_base = items_sent;
         while (items_sent - phase_base < PHASE_ITEMS) run_sequence();
      end

      wait_idle();
      repeat (8) @(posedge clock);
      $display("run covered %0d items (%0d evaluates, %0d starts) under %0d register settings",
               items_sent, evals_sent, starts_sent, settings_used + 1);
      $display("run saw %0d settled samples and %0d faults in %0d cycles",
               samples_seen, faults_seen, cycle_count);
      if (mismatch_count == 0) begin
         $display("relay_current_fault_monitor_tb: clean");
      end else begin
         $display("relay_current_fault_monitor_tb: errors");
      end
      $finish;
   end

endmodule
